/* rtl/max_heap_insert_delete_key_unit_defines.svh */
// ----------------------------------------------------------------------------
// Max-heap key unit assertion macros
// Shared concurrent assertion shorthands, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_INSERT_DELETE_KEY_UNIT_DEFINES_SVH
`define MAX_HEAP_INSERT_DELETE_KEY_UNIT_DEFINES_SVH

// same-cycle implication
`define MHK_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mhk assertion failed");

// next-cycle implication
`define MHK_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mhk assertion failed");

`endif

/* rtl/mhk_pkg.sv */
// ----------------------------------------------------------------------------
// Max-heap key unit package
// Field widths, operation and status codes, sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mhk_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 8;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_SCAN     = 11'b000_0000_0010,
      S_LAST_RD  = 11'b000_0000_0100,
      S_LAST_GET = 11'b000_0000_1000,
      S_DN_L     = 11'b000_0001_0000,
      S_DN_R     = 11'b000_0010_0000,
      S_DN_RC    = 11'b000_0100_0000,
      S_DN_CMP   = 11'b000_1000_0000,
      S_UP_RD    = 11'b001_0000_0000,
      S_UP_CMP   = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

/* rtl/mhk_ifs.sv */
// ----------------------------------------------------------------------------
// Max-heap key unit channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mhk_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic signed [mhk_pkg::KEY_W-1:0] key_value;

   modport source (output valid, kind, key_value, input ready);
   modport sink   (input valid, kind, key_value, output ready);
endinterface

interface mhk_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [mhk_pkg::STATUS_W-1:0] status;
   logic signed [mhk_pkg::KEY_W-1:0]    top_value;
   logic        [mhk_pkg::ENTRY_W-1:0]  entry_count;

   modport source (output valid, status, top_value, entry_count, input ready);
   modport sink   (input valid, status, top_value, entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/max_heap_insert_delete_key_unit.sv */
// Insert: one parent read and compare per level while sifting up.
// Delete: the linear scan reads one entry a cycle from the single-port store, then
//   sift-down reads the left and, if present, the right child per level, then sift-up.
// One item at a time; the next request transfer follows once the response is taken.
// Synchronous reset empties the heap (count zero); store contents are not cleared.
// ----------------------------------------------------------------------------
// Max-heap insert/delete-by-key unit
// Binary max-heap in a single-port store driven by a small sequencer around
// one shared signed greater-than comparator. Returns status, current maximum and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "max_heap_insert_delete_key_unit_defines.svh"

module max_heap_insert_delete_key_unit #(
   parameter int CAPACITY = 128
) (
   input wire logic  clock,
   input wire logic  reset,
   mhk_req_if.sink   req_chan,
   mhk_rsp_if.source rsp_chan
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;
   localparam int KW = mhk_pkg::KEY_W;

   logic signed [KW-1:0] mem [CAPACITY];

   mhk_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [AW-1:0]        chk_addr_ff, chk_addr_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        pick_pos_ff, pick_pos_in;
   logic signed [KW-1:0] val_ff, val_in;
   logic signed [KW-1:0] pick_val_ff, pick_val_in;
   logic signed [KW-1:0] key_ff, key_in;
   logic signed [KW-1:0] top_ff;
   logic signed [KW-1:0] rdata_ff;
   logic [mhk_pkg::STATUS_W-1:0] status_ff, status_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mhk_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic signed [KW-1:0]          rsp_top_ff, rsp_top_in;
   logic [mhk_pkg::ENTRY_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [KW-1:0] wr_data;
   logic [AW-1:0]        rd_addr;
   logic signed [KW-1:0] cmp_a, cmp_b;
   logic                 cmp_gt;
   logic                 req_xfer;

   logic [CW-1:0] cnt_m1;
   logic [AW-1:0] last_idx;
   logic [AW-1:0] parent;
   logic [LW-1:0] left_w, right_w, cnt_w;
   logic          scan_issue;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == mhk_pkg::S_IDLE) && !rsp_valid_ff;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.top_value   = rsp_top_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   assign cmp_gt = cmp_a > cmp_b;

   assign cnt_m1     = cnt_ff - CW'(1);
   assign last_idx   = cnt_m1[AW-1:0];
   assign parent     = AW'((pos_ff - AW'(1)) >> 1);
   assign left_w     = LW'({pos_ff, 1'b1});
   assign right_w    = left_w + LW'(1);
   assign cnt_w      = LW'(cnt_ff);
   assign scan_issue = scan_ff < cnt_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      pos_in        = pos_ff;
      pick_pos_in   = pick_pos_ff;
      val_in        = val_ff;
      pick_val_in   = pick_val_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = val_ff;
      rd_addr       = scan_ff[AW-1:0];
      cmp_a         = val_ff;
      cmp_b         = rdata_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mhk_pkg::S_IDLE: begin
            scan_in      = '0;
            chk_valid_in = 1'b0;
            if (req_xfer) begin
               key_in    = req_chan.key_value;
               val_in    = req_chan.key_value;
               status_in = mhk_pkg::ST_DONE;
               if (req_chan.kind == mhk_pkg::KIND_INSERT) begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     status_in = mhk_pkg::ST_FULL;
                     state_in  = mhk_pkg::S_DONE;
                  end else begin
                     pos_in   = cnt_ff[AW-1:0];
                     cnt_in   = cnt_ff + CW'(1);
                     state_in = mhk_pkg::S_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = mhk_pkg::ST_EMPTY;
                     state_in  = mhk_pkg::S_DONE;
                  end else begin
                     state_in = mhk_pkg::S_SCAN;
                  end
               end
            end
         end
         mhk_pkg::S_SCAN: begin
            rd_addr      = scan_ff[AW-1:0];
            chk_valid_in = scan_issue;
            chk_addr_in  = scan_ff[AW-1:0];
            if (scan_issue) begin
               scan_in = scan_ff + CW'(1);
            end
            if (chk_valid_ff && (rdata_ff == key_ff)) begin
               cnt_in       = cnt_m1;
               pos_in       = chk_addr_ff;
               chk_valid_in = 1'b0;
               if (chk_addr_ff == last_idx) begin
                  state_in = mhk_pkg::S_DONE;
               end else begin
                  state_in = mhk_pkg::S_LAST_RD;
               end
            end else if (chk_valid_ff && (chk_addr_ff == last_idx)) begin
               status_in    = mhk_pkg::ST_NOT_FOUND;
               chk_valid_in = 1'b0;
               state_in     = mhk_pkg::S_DONE;
            end
         end
         mhk_pkg::S_LAST_RD: begin
            // count already shrunk, so it indexes the old last entry
            rd_addr  = cnt_ff[AW-1:0];
            state_in = mhk_pkg::S_LAST_GET;
         end
         mhk_pkg::S_LAST_GET: begin
            val_in   = rdata_ff;
            state_in = mhk_pkg::S_DN_L;
         end
         mhk_pkg::S_DN_L: begin
            if (left_w >= cnt_w) begin
               state_in = mhk_pkg::S_UP_RD;
            end else begin
               rd_addr  = left_w[AW-1:0];
               state_in = mhk_pkg::S_DN_R;
            end
         end
         mhk_pkg::S_DN_R: begin
            pick_val_in = rdata_ff;
            pick_pos_in = left_w[AW-1:0];
            if (right_w < cnt_w) begin
               rd_addr  = right_w[AW-1:0];
               state_in = mhk_pkg::S_DN_RC;
            end else begin
               state_in = mhk_pkg::S_DN_CMP;
            end
         end
         mhk_pkg::S_DN_RC: begin
            // right wins only when strictly greater
            cmp_a = rdata_ff;
            cmp_b = pick_val_ff;
            if (cmp_gt) begin
               pick_val_in = rdata_ff;
               pick_pos_in = right_w[AW-1:0];
            end
            state_in = mhk_pkg::S_DN_CMP;
         end
         mhk_pkg::S_DN_CMP: begin
            cmp_a = pick_val_ff;
            cmp_b = val_ff;
            if (cmp_gt) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = pick_val_ff;
               pos_in   = pick_pos_ff;
               state_in = mhk_pkg::S_DN_L;
            end else begin
               state_in = mhk_pkg::S_UP_RD;
            end
         end
         mhk_pkg::S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               state_in = mhk_pkg::S_DONE;
            end else begin
               rd_addr  = parent;
               state_in = mhk_pkg::S_UP_CMP;
            end
         end
         mhk_pkg::S_UP_CMP: begin
            cmp_a = val_ff;
            cmp_b = rdata_ff;
            wr_en = 1'b1;
            wr_addr = pos_ff;
            if (cmp_gt) begin
               wr_data  = rdata_ff;
               pos_in   = parent;
               state_in = mhk_pkg::S_UP_RD;
            end else begin
               wr_data  = val_ff;
               state_in = mhk_pkg::S_DONE;
            end
         end
         mhk_pkg::S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_top_in    = (cnt_ff != '0) ? top_ff : '0;
            rsp_count_in  = mhk_pkg::ENTRY_W'(cnt_ff);
            state_in      = mhk_pkg::S_IDLE;
         end
         default: begin
            state_in = mhk_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhk_pkg::S_IDLE;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      chk_addr_ff   <= chk_addr_in;
      pos_ff        <= pos_in;
      pick_pos_ff   <= pick_pos_in;
      val_ff        <= val_in;
      pick_val_ff   <= pick_val_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `MHK_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(CAPACITY))
   `MHK_ASSERT_IMPL(a_wr_in_heap, clock, reset, wr_en, CW'(wr_addr) < cnt_ff)
   `MHK_ASSERT_IMPL(a_chk_in_heap, clock, reset, chk_valid_ff, CW'(chk_addr_ff) < cnt_ff)
   `MHK_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == mhk_pkg::S_DONE, rsp_valid_ff)
   `MHK_ASSERT_NEXT(a_req_busy, clock, reset, req_xfer, state_ff != mhk_pkg::S_IDLE)

endmodule

`default_nettype wire
